// ----- sv/aeha_pkg.sv -----
package aeha_pkg;

    // internal arithmetic width: 32-bit values plus header, alignment and carry room
    localparam int DW           = 35;
    localparam int ALIGN_W      = 17;
    localparam int FREE_ENTRY_W = 64;
    localparam int USED_ENTRY_W = 96;

    typedef enum logic [2:0] {
        ACT_ALLOC   = 3'd0,
        ACT_FREE    = 3'd1,
        ACT_RESIZE  = 3'd2,
        ACT_TOTAL   = 3'd3,
        ACT_LARGEST = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_FIT_MODE   = 2'd0,
        REG_REUSE      = 2'd1,
        REG_HEAP_START = 2'd2,
        REG_HEAP_END   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_DOWN,
        SH_UP
    } shift_t;

    typedef enum logic [1:0] {
        STEP_DEC,
        STEP_HOLD,
        STEP_INC
    } cnt_step_t;

    typedef enum logic [1:0] {
        REL_FREE,
        REL_SHRINK,
        REL_GROW_FIND,
        REL_GROW_REL
    } rel_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_PLAN,
        S_SUM_SCAN,
        S_MAX_SCAN,
        S_USED_SCAN,
        S_USED_PLAN,
        S_REL_START,
        S_REL_SCAN,
        S_REL_PLAN,
        S_FREE_MOVE,
        S_EDIT_START,
        S_EDIT_SHIFT,
        S_EDIT_WR,
        S_EDIT_WR2,
        S_FINISH
    } state_t;

endpackage

// ----- sv/aeha_ram.sv -----
module aeha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/aligned_extent_heap_allocator.sv -----
// Sequence: allocate scans the free table and then shifts entries to open or close a slot;
//   free and resize first scan the used table, then the free table, then shift; a growing
//   resize that hands back the rest scans and shifts the free table twice.
// Throughput: one transaction at a time; the single read port of each table memory sets
//   the pace. Queries scan every free extent.
// Reset: aresetn is synchronous, active low; tables are empty, no clearing pass is needed.
module aligned_extent_heap_allocator
    import aeha_pkg::*;
#(
    parameter int MAX_FREE_EXTENTS = 64,
    parameter int MAX_USED_BLOCKS  = 64,
    parameter int HEADER_BYTES     = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_index,
    input  logic [31:0]  cfg_wr_data,
    // request channel
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_action,
    input  logic [31:0]  s_size,
    input  logic [16:0]  s_alignment,
    input  logic         s_from_end,
    input  logic [31:0]  s_block_addr,
    // result channel
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_status,
    output logic [31:0]  m_address,
    output logic [31:0]  m_amount
);

    localparam int FAW = $clog2(MAX_FREE_EXTENTS);
    localparam int FCW = $clog2(MAX_FREE_EXTENTS + 1);
    localparam int UAW = (MAX_USED_BLOCKS > 1) ? $clog2(MAX_USED_BLOCKS) : 1;
    localparam int UCW = $clog2(MAX_USED_BLOCKS + 1);
    localparam int IW  = (FCW > UCW) ? FCW : UCW;

    localparam logic [DW-1:0]  HDR  = DW'(HEADER_BYTES);
    localparam logic [DW-1:0]  HDR4 = DW'(HEADER_BYTES + 4);
    localparam logic [FCW-1:0] FMAX = FCW'(MAX_FREE_EXTENTS);
    localparam logic [UCW-1:0] UMAX = UCW'(MAX_USED_BLOCKS);

    // alignment cut to its highest set bit, at least four
    function automatic logic [ALIGN_W-1:0] norm_align(input logic [ALIGN_W-1:0] a);
        logic [ALIGN_W-1:0] r;
        r = '0;
        for (int i = 0; i < ALIGN_W; i++) begin
            if (a[i]) begin
                r = ALIGN_W'(1) << i;
            end
        end
        if (r < ALIGN_W'(4)) begin
            r = ALIGN_W'(4);
        end
        return r;
    endfunction

    state_t                   state_reg, state_next;
    logic                     fit_mode_reg, fit_mode_next;
    logic                     reuse_reg, reuse_next;
    logic [31:0]              hstart_reg, hstart_next;
    logic [FCW-1:0]           fcnt_reg, fcnt_next;
    logic [UCW-1:0]           ucnt_reg, ucnt_next;
    logic [IW-1:0]            idx_reg, idx_next;
    action_t                  act_reg, act_next;
    logic [DW-1:0]            size_reg, size_next;
    logic [ALIGN_W-1:0]       amask_reg, amask_next;
    logic                     tail_reg, tail_next;
    logic [31:0]              baddr_reg, baddr_next;
    logic                     found_reg, found_next;
    logic [DW-1:0]            best_reg, best_next;
    logic [DW-1:0]            adst_reg, adst_next;
    logic [FCW-1:0]           p_reg, p_next;
    logic [UAW-1:0]           k_reg, k_next;
    logic [31:0]              cur_start_reg, cur_start_next;
    logic [31:0]              cur_end_reg, cur_end_next;
    logic [31:0]              prev_start_reg, prev_start_next;
    logic [31:0]              prev_end_reg, prev_end_next;
    logic [DW-1:0]            ms_reg, ms_next;
    logic [DW-1:0]            me_reg, me_next;
    logic [31:0]              ua_reg, ua_next;
    logic [31:0]              upad_reg, upad_next;
    logic [31:0]              usz_reg, usz_next;
    rel_mode_t                rel_mode_reg, rel_mode_next;
    shift_t                   sh_dir_reg, sh_dir_next;
    logic [FCW-1:0]           sh_pos_reg, sh_pos_next;
    logic                     wr0_en_reg, wr0_en_next;
    logic [FAW-1:0]           wr0_pos_reg, wr0_pos_next;
    logic [FREE_ENTRY_W-1:0]  wr0_data_reg, wr0_data_next;
    logic                     wr1_en_reg, wr1_en_next;
    logic [FAW-1:0]           wr1_pos_reg, wr1_pos_next;
    logic [FREE_ENTRY_W-1:0]  wr1_data_reg, wr1_data_next;
    cnt_step_t                step_reg, step_next;
    logic                     cont_reg, cont_next;
    status_t                  res_status_reg, res_status_next;
    logic [31:0]              res_address_reg, res_address_next;
    logic [31:0]              res_amount_reg, res_amount_next;
    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               m_status_reg, m_status_next;
    logic [31:0]              m_address_reg, m_address_next;
    logic [31:0]              m_amount_reg, m_amount_next;

    // memory ports
    logic                     f_we;
    logic [FAW-1:0]           f_waddr, f_raddr;
    logic [FREE_ENTRY_W-1:0]  f_wdata, f_rdata;
    logic                     u_we;
    logic [UAW-1:0]           u_waddr, u_raddr;
    logic [USED_ENTRY_W-1:0]  u_wdata, u_rdata;

    aeha_ram #(.WIDTH(FREE_ENTRY_W), .DEPTH(MAX_FREE_EXTENTS)) u_free_ram (
        .clk   (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    aeha_ram #(.WIDTH(USED_ENTRY_W), .DEPTH(MAX_USED_BLOCKS)) u_used_ram (
        .clk   (aclk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    // free extent under the scan and its fit for an allocation
    logic [DW-1:0] fs, fe, amask, ds, head_up, fe_dn, fe_ms, tail_cand, cand, room_key;
    logic          fit, take, last_f, last_u, rel_hit, u_hit, out_free;

    assign fs        = DW'(f_rdata[63:32]);
    assign fe        = DW'(f_rdata[31:0]);
    assign amask     = DW'(amask_reg);
    assign ds        = fs + HDR;
    assign head_up   = (ds + amask) & ~amask;
    assign fe_dn     = fe & ~amask;
    assign fe_ms     = fe - size_reg;
    assign tail_cand = fe_ms & ~amask;
    assign cand      = tail_reg ? tail_cand : head_up;
    assign fit       = tail_reg ? ((fe >= ds + size_reg) && (tail_cand >= ds))
                                : (head_up + size_reg <= fe);
    assign room_key  = tail_reg ? ((fe_dn <= ds) ? '0 : fe_dn - ds)
                                : ((head_up >= fe) ? '0 : fe - head_up);
    assign take      = fit && (!fit_mode_reg || (room_key < best_reg));
    assign last_f    = (idx_reg == IW'(fcnt_reg) - IW'(1));
    assign last_u    = (idx_reg == IW'(ucnt_reg) - IW'(1));
    assign rel_hit   = (fs >= ms_reg);
    assign u_hit     = (u_rdata[95:64] == baddr_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // allocation split of the chosen extent
    logic [DW-1:0] fs_r, fe_r, top, bot, alloc_end;
    logic          reltop, relbot, too_many;
    logic [FCW:0]  pieces;

    assign fs_r      = DW'(cur_start_reg);
    assign fe_r      = DW'(cur_end_reg);
    assign top       = adst_reg - fs_r - HDR;
    assign alloc_end = adst_reg + size_reg;
    assign bot       = fe_r - alloc_end;
    assign reltop    = (reuse_reg || tail_reg) && (top > HDR4);
    assign relbot    = (reuse_reg || !tail_reg) && (bot > HDR4);
    assign pieces    = (FCW+1)'(reltop) + (FCW+1)'(relbot);
    assign too_many  = ((FCW+1)'(fcnt_reg) + pieces) > ((FCW+1)'(fcnt_reg == '0) +
                       (FCW+1)'(MAX_FREE_EXTENTS) + (FCW+1)'(1));

    // neighbors of a released span
    logic          has_prev, has_next, mprev, mnext, fits;
    logic [DW-1:0] room, grow, room_left, grow_bs;
    logic          grow_ok, grow_keep;

    assign has_prev  = (p_reg != '0);
    assign has_next  = (p_reg < fcnt_reg);
    assign mprev     = has_prev && (DW'(prev_end_reg) == ms_reg);
    assign mnext     = has_next && (fs_r == me_reg);
    assign fits      = mprev || mnext || (fcnt_reg < FMAX);
    assign room      = fe_r - fs_r;
    assign grow      = size_reg - DW'(usz_reg);
    assign grow_ok   = has_next && (fs_r == ms_reg) && (grow <= room);
    assign room_left = room - grow;
    assign grow_keep = (room_left >= HDR4);
    assign grow_bs   = grow_keep ? size_reg : size_reg + room_left;

    // region rebuild on a write of the end address
    logic          rebuild;
    logic [DW-1:0] rb_start, rb_end;
    logic          rb_ok;

    assign rebuild  = cfg_wr_en && (cfg_wr_index == REG_HEAP_END);
    assign rb_start = (DW'(hstart_reg) + DW'(3)) & ~DW'(3);
    assign rb_end   = DW'(cfg_wr_data) & ~DW'(3);
    assign rb_ok    = (rb_end >= rb_start + HDR4);

    // edit sequencer conditions
    logic sh_go, sh_done;

    assign sh_go   = ((sh_dir_reg == SH_DOWN) &&
                      ((FCW+1)'(sh_pos_reg) + (FCW+1)'(1) < (FCW+1)'(fcnt_reg))) ||
                     ((sh_dir_reg == SH_UP) && (sh_pos_reg < fcnt_reg));
    assign sh_done = (sh_dir_reg == SH_DOWN) ? last_f : (idx_reg == IW'(sh_pos_reg));

    // resize decision on the found block
    logic [DW-1:0] bend, shrink_rel;
    logic          is_shrink, is_grow;

    assign bend       = DW'(ua_reg) + DW'(usz_reg);
    assign is_shrink  = size_reg < DW'(usz_reg);
    assign is_grow    = size_reg > DW'(usz_reg);
    assign shrink_rel = DW'(usz_reg) - size_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_action)
                        ACT_ALLOC: begin
                            if (ucnt_reg >= UMAX || fcnt_reg == '0) begin
                                state_next = S_FINISH;
                            end else begin
                                state_next = S_ALLOC_SCAN;
                            end
                        end
                        ACT_FREE: begin
                            if (s_block_addr == '0 || ucnt_reg == '0) begin
                                state_next = S_FINISH;
                            end else begin
                                state_next = S_USED_SCAN;
                            end
                        end
                        ACT_RESIZE: begin
                            state_next = (ucnt_reg == '0) ? S_FINISH : S_USED_SCAN;
                        end
                        ACT_TOTAL: begin
                            state_next = (fcnt_reg == '0) ? S_FINISH : S_SUM_SCAN;
                        end
                        ACT_LARGEST: begin
                            state_next = (fcnt_reg == '0) ? S_FINISH : S_MAX_SCAN;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_ALLOC_SCAN: begin
                if ((fit && !fit_mode_reg) || last_f) begin
                    state_next = S_ALLOC_PLAN;
                end
            end
            S_ALLOC_PLAN: begin
                state_next = (!found_reg || too_many) ? S_FINISH : S_EDIT_START;
            end
            S_SUM_SCAN, S_MAX_SCAN: begin
                if (last_f) begin
                    state_next = S_FINISH;
                end
            end
            S_USED_SCAN: begin
                if (u_hit) begin
                    state_next = S_USED_PLAN;
                end else if (last_u) begin
                    state_next = S_FINISH;
                end
            end
            S_USED_PLAN: begin
                if (act_reg == ACT_FREE || is_grow ||
                    (is_shrink && shrink_rel > HDR4)) begin
                    state_next = S_REL_START;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_REL_START: begin
                state_next = (fcnt_reg == '0) ? S_REL_PLAN : S_REL_SCAN;
            end
            S_REL_SCAN: begin
                if (rel_hit || last_f) begin
                    state_next = S_REL_PLAN;
                end
            end
            S_REL_PLAN: begin
                if (rel_mode_reg == REL_GROW_FIND) begin
                    state_next = grow_ok ? S_EDIT_START : S_FINISH;
                end else if (!fits) begin
                    state_next = S_FINISH;
                end else if (rel_mode_reg == REL_FREE) begin
                    state_next = S_FREE_MOVE;
                end else begin
                    state_next = S_EDIT_START;
                end
            end
            S_FREE_MOVE: begin
                state_next = S_EDIT_START;
            end
            S_EDIT_START: begin
                state_next = sh_go ? S_EDIT_SHIFT : S_EDIT_WR;
            end
            S_EDIT_SHIFT: begin
                if (sh_done) begin
                    state_next = S_EDIT_WR;
                end
            end
            S_EDIT_WR: begin
                if (wr1_en_reg) begin
                    state_next = S_EDIT_WR2;
                end else begin
                    state_next = cont_reg ? S_REL_START : S_FINISH;
                end
            end
            S_EDIT_WR2: begin
                state_next = cont_reg ? S_REL_START : S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory ports
    always_comb begin
        fit_mode_next    = fit_mode_reg;
        reuse_next       = reuse_reg;
        hstart_next      = hstart_reg;
        fcnt_next        = fcnt_reg;
        ucnt_next        = ucnt_reg;
        idx_next         = idx_reg;
        act_next         = act_reg;
        size_next        = size_reg;
        amask_next       = amask_reg;
        tail_next        = tail_reg;
        baddr_next       = baddr_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        adst_next        = adst_reg;
        p_next           = p_reg;
        k_next           = k_reg;
        cur_start_next   = cur_start_reg;
        cur_end_next     = cur_end_reg;
        prev_start_next  = prev_start_reg;
        prev_end_next    = prev_end_reg;
        ms_next          = ms_reg;
        me_next          = me_reg;
        ua_next          = ua_reg;
        upad_next        = upad_reg;
        usz_next         = usz_reg;
        rel_mode_next    = rel_mode_reg;
        sh_dir_next      = sh_dir_reg;
        sh_pos_next      = sh_pos_reg;
        wr0_en_next      = wr0_en_reg;
        wr0_pos_next     = wr0_pos_reg;
        wr0_data_next    = wr0_data_reg;
        wr1_en_next      = wr1_en_reg;
        wr1_pos_next     = wr1_pos_reg;
        wr1_data_next    = wr1_data_reg;
        step_next        = step_reg;
        cont_next        = cont_reg;
        res_status_next  = res_status_reg;
        res_address_next = res_address_reg;
        res_amount_next  = res_amount_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_address_next   = m_address_reg;
        m_amount_next    = m_amount_reg;

        f_we    = 1'b0;
        f_waddr = '0;
        f_wdata = '0;
        f_raddr = '0;
        u_we    = 1'b0;
        u_waddr = k_reg;
        u_wdata = '0;
        u_raddr = '0;

        // configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FIT_MODE:   fit_mode_next = cfg_wr_data[0];
                REG_REUSE:      reuse_next    = cfg_wr_data[0];
                REG_HEAP_START: hstart_next   = cfg_wr_data;
                REG_HEAP_END: begin
                    ucnt_next = '0;
                    fcnt_next = rb_ok ? FCW'(1) : '0;
                end
                default: ;
            endcase
        end
        if (rebuild && rb_ok) begin
            f_we    = 1'b1;
            f_waddr = '0;
            f_wdata = {rb_start[31:0], rb_end[31:0]};
        end

        // result register toward the consumer
        if (state_reg == S_FINISH && out_free) begin
            m_valid_next   = 1'b1;
            m_status_next  = res_status_reg;
            m_address_next = res_address_reg;
            m_amount_next  = res_amount_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                idx_next         = '0;
                act_next         = action_t'(s_action);
                amask_next       = norm_align(s_alignment) - ALIGN_W'(1);
                tail_next        = s_from_end;
                baddr_next       = s_block_addr;
                found_next       = 1'b0;
                best_next        = (s_action == ACT_LARGEST) ? '0 : DW'(32'hFFFF_FFFF);
                res_status_next  = ST_OK;
                res_address_next = '0;
                res_amount_next  = '0;
                if (s_action == ACT_ALLOC) begin
                    size_next = (DW'((s_size == '0) ? 32'd1 : s_size) + DW'(3)) & ~DW'(3);
                end else begin
                    size_next = (DW'(s_size) + DW'(3)) & ~DW'(3);
                end
                if (s_valid) begin
                    if (s_action == ACT_ALLOC) begin
                        if (ucnt_reg >= UMAX) begin
                            res_status_next = ST_FULL;
                        end else if (fcnt_reg == '0) begin
                            res_status_next = ST_NO_SPACE;
                        end
                    end else if ((s_action == ACT_FREE && s_block_addr != '0) ||
                                 s_action == ACT_RESIZE) begin
                        if (ucnt_reg == '0) begin
                            res_status_next = ST_UNKNOWN;
                        end
                    end
                end
            end
            S_ALLOC_SCAN: begin
                f_raddr  = FAW'(idx_reg + IW'(1));
                idx_next = idx_reg + IW'(1);
                if (take) begin
                    found_next     = 1'b1;
                    best_next      = room_key;
                    adst_next      = cand;
                    p_next         = FCW'(idx_reg);
                    cur_start_next = f_rdata[63:32];
                    cur_end_next   = f_rdata[31:0];
                end
            end
            S_ALLOC_PLAN: begin
                if (!found_reg) begin
                    res_status_next = ST_NO_SPACE;
                end else if (too_many) begin
                    res_status_next = ST_FULL;
                end else begin
                    // the new used block goes to the end of the used table
                    u_we    = 1'b1;
                    u_waddr = UAW'(ucnt_reg);
                    u_wdata = {adst_reg[31:0], reltop ? 32'd0 : top[31:0],
                               relbot ? size_reg[31:0] : (size_reg[31:0] + bot[31:0])};
                    ucnt_next        = ucnt_reg + UCW'(1);
                    res_address_next = adst_reg[31:0];
                    cont_next        = 1'b0;
                    wr1_en_next      = 1'b0;
                    wr0_en_next      = 1'b0;
                    sh_dir_next      = SH_NONE;
                    step_next        = STEP_HOLD;
                    sh_pos_next      = p_reg;
                    if (reltop && relbot) begin
                        sh_dir_next   = SH_UP;
                        sh_pos_next   = p_reg + FCW'(1);
                        step_next     = STEP_INC;
                        wr0_en_next   = 1'b1;
                        wr0_pos_next  = FAW'(p_reg);
                        wr0_data_next = {cur_start_reg, 32'(fs_r + top)};
                        wr1_en_next   = 1'b1;
                        wr1_pos_next  = FAW'(p_reg + FCW'(1));
                        wr1_data_next = {alloc_end[31:0], cur_end_reg};
                    end else if (reltop) begin
                        wr0_en_next   = 1'b1;
                        wr0_pos_next  = FAW'(p_reg);
                        wr0_data_next = {cur_start_reg, 32'(fs_r + top)};
                    end else if (relbot) begin
                        wr0_en_next   = 1'b1;
                        wr0_pos_next  = FAW'(p_reg);
                        wr0_data_next = {alloc_end[31:0], cur_end_reg};
                    end else begin
                        sh_dir_next = SH_DOWN;
                        step_next   = STEP_DEC;
                    end
                end
            end
            S_SUM_SCAN: begin
                f_raddr         = FAW'(idx_reg + IW'(1));
                idx_next        = idx_reg + IW'(1);
                res_amount_next = res_amount_reg + 32'(fe - fs - HDR);
            end
            S_MAX_SCAN: begin
                f_raddr  = FAW'(idx_reg + IW'(1));
                idx_next = idx_reg + IW'(1);
                if (room_key > best_reg) begin
                    best_next       = room_key;
                    res_amount_next = room_key[31:0];
                end
            end
            S_USED_SCAN: begin
                u_raddr  = UAW'(idx_reg + IW'(1));
                idx_next = idx_reg + IW'(1);
                if (u_hit) begin
                    k_next    = UAW'(idx_reg);
                    ua_next   = u_rdata[95:64];
                    upad_next = u_rdata[63:32];
                    usz_next  = u_rdata[31:0];
                end else if (last_u) begin
                    res_status_next = ST_UNKNOWN;
                end
            end
            S_USED_PLAN: begin
                if (act_reg == ACT_FREE) begin
                    ms_next       = DW'(ua_reg) - HDR - DW'(upad_reg);
                    me_next       = bend;
                    rel_mode_next = REL_FREE;
                end else if (is_grow) begin
                    ms_next       = bend;
                    rel_mode_next = REL_GROW_FIND;
                end else begin
                    ms_next         = DW'(ua_reg) + size_reg;
                    me_next         = bend;
                    rel_mode_next   = REL_SHRINK;
                    res_amount_next = usz_reg;
                end
            end
            S_REL_START: begin
                f_raddr  = '0;
                idx_next = '0;
                p_next   = '0;
            end
            S_REL_SCAN: begin
                f_raddr  = FAW'(idx_reg + IW'(1));
                idx_next = idx_reg + IW'(1);
                if (rel_hit) begin
                    p_next         = FCW'(idx_reg);
                    cur_start_next = f_rdata[63:32];
                    cur_end_next   = f_rdata[31:0];
                end else begin
                    p_next          = FCW'(idx_reg) + FCW'(1);
                    prev_start_next = f_rdata[63:32];
                    prev_end_next   = f_rdata[31:0];
                end
            end
            S_REL_PLAN: begin
                u_raddr     = UAW'(ucnt_reg - UCW'(1));
                wr0_en_next = 1'b0;
                wr1_en_next = 1'b0;
                cont_next   = 1'b0;
                sh_dir_next = SH_NONE;
                sh_pos_next = p_reg;
                step_next   = STEP_HOLD;
                if (rel_mode_reg == REL_GROW_FIND) begin
                    if (!grow_ok) begin
                        res_status_next = ST_NO_SPACE;
                        res_amount_next = '0;
                    end else begin
                        // take the following extent and hand back what stays over
                        sh_dir_next     = SH_DOWN;
                        step_next       = STEP_DEC;
                        u_we            = 1'b1;
                        u_wdata         = {ua_reg, upad_reg, grow_bs[31:0]};
                        res_amount_next = grow_bs[31:0];
                        cont_next       = grow_keep;
                        ms_next         = fe_r - room_left;
                        me_next         = fe_r;
                        rel_mode_next   = REL_GROW_REL;
                    end
                end else if (!fits) begin
                    res_status_next = ST_FULL;
                end else begin
                    if (rel_mode_reg == REL_SHRINK) begin
                        u_we            = 1'b1;
                        u_wdata         = {ua_reg, upad_reg, size_reg[31:0]};
                        res_amount_next = size_reg[31:0];
                    end
                    wr0_en_next = 1'b1;
                    if (mprev && mnext) begin
                        sh_dir_next   = SH_DOWN;
                        step_next     = STEP_DEC;
                        wr0_pos_next  = FAW'(p_reg - FCW'(1));
                        wr0_data_next = {prev_start_reg, cur_end_reg};
                    end else if (mprev) begin
                        wr0_pos_next  = FAW'(p_reg - FCW'(1));
                        wr0_data_next = {prev_start_reg, me_reg[31:0]};
                    end else if (mnext) begin
                        wr0_pos_next  = FAW'(p_reg);
                        wr0_data_next = {ms_reg[31:0], cur_end_reg};
                    end else begin
                        sh_dir_next   = SH_UP;
                        step_next     = STEP_INC;
                        wr0_pos_next  = FAW'(p_reg);
                        wr0_data_next = {ms_reg[31:0], me_reg[31:0]};
                    end
                end
            end
            S_FREE_MOVE: begin
                // last used entry fills the hole
                u_we      = 1'b1;
                u_wdata   = u_rdata;
                ucnt_next = ucnt_reg - UCW'(1);
            end
            S_EDIT_START: begin
                if (sh_dir_reg == SH_DOWN) begin
                    f_raddr  = FAW'(sh_pos_reg + FCW'(1));
                    idx_next = IW'(sh_pos_reg) + IW'(1);
                end else begin
                    f_raddr  = FAW'(fcnt_reg - FCW'(1));
                    idx_next = IW'(fcnt_reg) - IW'(1);
                end
            end
            S_EDIT_SHIFT: begin
                f_we    = 1'b1;
                f_wdata = f_rdata;
                if (sh_dir_reg == SH_DOWN) begin
                    f_waddr  = FAW'(idx_reg - IW'(1));
                    f_raddr  = FAW'(idx_reg + IW'(1));
                    idx_next = idx_reg + IW'(1);
                end else begin
                    f_waddr  = FAW'(idx_reg + IW'(1));
                    f_raddr  = FAW'(idx_reg - IW'(1));
                    idx_next = idx_reg - IW'(1);
                end
            end
            S_EDIT_WR: begin
                f_we    = wr0_en_reg;
                f_waddr = wr0_pos_reg;
                f_wdata = wr0_data_reg;
                unique case (step_reg)
                    STEP_DEC:  fcnt_next = fcnt_reg - FCW'(1);
                    STEP_INC:  fcnt_next = fcnt_reg + FCW'(1);
                    default:   fcnt_next = fcnt_reg;
                endcase
            end
            S_EDIT_WR2: begin
                f_we    = 1'b1;
                f_waddr = wr1_pos_reg;
                f_wdata = wr1_data_reg;
            end
            S_FINISH: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fit_mode_reg <= 1'b0;
            reuse_reg    <= 1'b0;
            hstart_reg   <= '0;
            fcnt_reg     <= '0;
            ucnt_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fit_mode_reg <= fit_mode_next;
            reuse_reg    <= reuse_next;
            hstart_reg   <= hstart_next;
            fcnt_reg     <= fcnt_next;
            ucnt_reg     <= ucnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        act_reg         <= act_next;
        size_reg        <= size_next;
        amask_reg       <= amask_next;
        tail_reg        <= tail_next;
        baddr_reg       <= baddr_next;
        found_reg       <= found_next;
        best_reg        <= best_next;
        adst_reg        <= adst_next;
        p_reg           <= p_next;
        k_reg           <= k_next;
        cur_start_reg   <= cur_start_next;
        cur_end_reg     <= cur_end_next;
        prev_start_reg  <= prev_start_next;
        prev_end_reg    <= prev_end_next;
        ms_reg          <= ms_next;
        me_reg          <= me_next;
        ua_reg          <= ua_next;
        upad_reg        <= upad_next;
        usz_reg         <= usz_next;
        rel_mode_reg    <= rel_mode_next;
        sh_dir_reg      <= sh_dir_next;
        sh_pos_reg      <= sh_pos_next;
        wr0_en_reg      <= wr0_en_next;
        wr0_pos_reg     <= wr0_pos_next;
        wr0_data_reg    <= wr0_data_next;
        wr1_en_reg      <= wr1_en_next;
        wr1_pos_reg     <= wr1_pos_next;
        wr1_data_reg    <= wr1_data_next;
        step_reg        <= step_next;
        cont_reg        <= cont_next;
        res_status_reg  <= res_status_next;
        res_address_reg <= res_address_next;
        res_amount_reg  <= res_amount_next;
        m_status_reg    <= m_status_next;
        m_address_reg   <= m_address_next;
        m_amount_reg    <= m_amount_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_address = m_address_reg;
    assign m_amount  = m_amount_reg;

`ifndef ASSERT_OFF
    a_free_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= FMAX)
        else $error("free extent count above table size");

    a_used_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ucnt_reg <= UMAX)
        else $error("used block count above table size");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while one is in progress");

    a_open_slot_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EDIT_SHIFT && sh_dir_reg == SH_UP) |-> (fcnt_reg < FMAX))
        else $error("opening a slot in a full free table");
`endif

endmodule
